// File: design/constrained_shortest_path_unit_defines.svh
// assertion macros used by the solver (cspu_solver)
`ifndef CONSTRAINED_SHORTEST_PATH_UNIT_DEFINES_SVH
`define CONSTRAINED_SHORTEST_PATH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CSPU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CSPU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSPU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CSPU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: design/cspu_pkg.sv
`timescale 1ns / 1ps
package cspu_pkg;

  localparam int MAX_LINKS        = 32;
  localparam int MAX_VERTICES     = 64;
  localparam int MAX_DESTINATIONS = 16;
  localparam int PRIORITY_CLASSES = 8;

  localparam int LINK_W = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int LCNT_W = $clog2(MAX_LINKS + 1);
  localparam int DEST_W = (MAX_DESTINATIONS > 1) ? $clog2(MAX_DESTINATIONS) : 1;
  localparam int DCNT_W = $clog2(MAX_DESTINATIONS + 1);
  localparam int VTX_W  = $clog2(MAX_VERTICES);
  localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
  localparam int CLS_W  = (PRIORITY_CLASSES > 1) ? $clog2(PRIORITY_CLASSES) : 1;

  localparam int ADDR_W = 32;
  localparam int BW_W   = 40;
  localparam int COST_W = 16;
  localparam int DIST_W = 24;
  localparam int PAR_W  = 7;
  localparam logic [PAR_W-1:0] NO_PARENT = 7'd127;

  typedef enum logic [2:0] {
    ACT_LINK    = 3'd0,
    ACT_CLASS   = 3'd1,
    ACT_DEST    = 3'd2,
    ACT_COMPUTE = 3'd3,
    ACT_CLEAR   = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    CFG_SOURCE = 2'd0,
    CFG_BW     = 2'd1,
    CFG_CLASS  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_ROUTER = 2'd0,
    PH_NEIGH  = 2'd1,
    PH_SOURCE = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LINK_RD, ST_LINK_CHK, ST_SRCH_RD, ST_SRCH_CMP, ST_HIT,
    ST_PASS, ST_EDGE_RD, ST_DIST_RD, ST_RELAX, ST_SEL_RD, ST_SEL_CHK,
    ST_DST_RD, ST_DST_CMP, ST_PATH_WR, ST_PATH_PAR, ST_OUT_RD, ST_OUT_VA,
    ST_OUT_PUT, ST_OVF_OUT, ST_NONE_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [ADDR_W-1:0] node;
    logic [ADDR_W-1:0] neighbor;
    logic              up;
    logic [COST_W-1:0] cost;
    logic [2:0]        cls;
    logic [BW_W-1:0]   bw;
  } load_t;

  typedef struct packed {
    logic              link_rd;
    logic [LINK_W-1:0] link_idx;
    logic              dest_rd;
    logic [DEST_W-1:0] dest_idx;
    logic              set_ovf;
  } tbl_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] router;
    logic [ADDR_W-1:0] neighbor;
    logic              up;
    logic [COST_W-1:0] metric;
    logic [BW_W-1:0]   bw;
    logic [ADDR_W-1:0] dest;
    logic [LCNT_W-1:0] link_count;
    logic [DCNT_W-1:0] dest_count;
    logic              ovf;
  } tbl_rsp_t;

  typedef struct packed {
    logic              load;
    logic [ADDR_W-1:0] hop;
    logic              found;
    logic              ovf;
    logic              last;
  } res_t;

endpackage

// File: design/cspu_tables.sv
`timescale 1ns / 1ps
module cspu_tables (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  cspu_pkg::load_t   load,
  input  logic [2:0]        pclass,
  input  cspu_pkg::tbl_req_t req,
  output cspu_pkg::tbl_rsp_t rsp
);
  import cspu_pkg::*;

  localparam int LINK_MW = 2 * ADDR_W + 1 + COST_W;
  localparam int BW_DEPTH = 2 ** (LINK_W + CLS_W);

  logic [LINK_MW-1:0] link_mem [MAX_LINKS];
  logic [BW_W-1:0]    bw_mem [BW_DEPTH];
  logic [ADDR_W-1:0]  dest_mem [MAX_DESTINATIONS];
  logic [PRIORITY_CLASSES-1:0] bw_valid [MAX_LINKS];

  logic [LCNT_W-1:0] link_count;
  logic [DCNT_W-1:0] dest_count;
  logic              ovf;
  logic [LINK_MW-1:0] link_q;
  logic [BW_W-1:0]    bw_q;
  logic               bw_ok;
  logic [ADDR_W-1:0]  dest_q;

  logic              link_full, dest_full, class_ok;
  logic [LINK_W-1:0] wr_link, last_link;

  assign link_full = link_count >= LCNT_W'(MAX_LINKS);
  assign dest_full = dest_count >= DCNT_W'(MAX_DESTINATIONS);
  assign class_ok  = 32'(load.cls) < PRIORITY_CLASSES;
  assign wr_link   = link_count[LINK_W-1:0];
  assign last_link = LINK_W'(link_count - LCNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      link_count <= '0;
      dest_count <= '0;
      ovf <= 1'b0;
    end else begin
      if (req.set_ovf) ovf <= 1'b1;
      if (load_valid) begin
        unique case (load.action)
          ACT_LINK: begin
            if (link_full) ovf <= 1'b1;
            else link_count <= link_count + LCNT_W'(1);
          end
          ACT_DEST: begin
            if (dest_full) ovf <= 1'b1;
            else dest_count <= dest_count + DCNT_W'(1);
          end
          ACT_CLEAR: begin
            link_count <= '0;
            dest_count <= '0;
            ovf <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // per-link class valid bits stand in for zeroing all class bandwidths
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < MAX_LINKS; n++) bw_valid[n] <= '0;
    end else if (load_valid) begin
      if (load.action == ACT_LINK && !link_full) begin
        bw_valid[wr_link] <= '0;
      end else if (load.action == ACT_CLASS && link_count != '0 && !ovf && class_ok) begin
        bw_valid[last_link][load.cls[CLS_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load.action == ACT_LINK && !link_full) begin
      link_mem[wr_link] <= {load.node, load.neighbor, load.up, load.cost};
    end
    if (load_valid && load.action == ACT_CLASS && link_count != '0 && !ovf && class_ok) begin
      bw_mem[{last_link, load.cls[CLS_W-1:0]}] <= load.bw;
    end
    if (load_valid && load.action == ACT_DEST && !dest_full) begin
      dest_mem[dest_count[DEST_W-1:0]] <= load.node;
    end
    if (req.link_rd) begin
      link_q <= link_mem[req.link_idx];
      bw_q   <= bw_mem[{req.link_idx, pclass[CLS_W-1:0]}];
      bw_ok  <= bw_valid[req.link_idx][pclass[CLS_W-1:0]] &&
                (32'(pclass) < PRIORITY_CLASSES);
    end
    if (req.dest_rd) dest_q <= dest_mem[req.dest_idx];
  end

  always_comb begin
    {rsp.router, rsp.neighbor, rsp.up, rsp.metric} = link_q;
    rsp.bw         = bw_ok ? bw_q : '0;
    rsp.dest       = dest_q;
    rsp.link_count = link_count;
    rsp.dest_count = dest_count;
    rsp.ovf        = ovf;
  end

endmodule

// File: design/cspu_solver.sv
`timescale 1ns / 1ps
`include "constrained_shortest_path_unit_defines.svh"
module cspu_solver (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         source_router,
  input  logic [39:0]         required_bandwidth,
  input  logic                out_free,
  input  cspu_pkg::tbl_rsp_t  tbl,
  output cspu_pkg::tbl_req_t  req,
  output cspu_pkg::res_t      res,
  output logic                idle
);
  import cspu_pkg::*;

  localparam int EDGE_W = 2 * VTX_W + COST_W;

  logic [ADDR_W-1:0] va_mem [MAX_VERTICES];
  logic [DIST_W-1:0] dist_mem [MAX_VERTICES];
  logic [PAR_W-1:0]  par_mem [MAX_VERTICES];
  logic [EDGE_W-1:0] edge_mem [MAX_LINKS];
  logic [VTX_W-1:0]  path_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] reached, reached_next;

  state_t state, state_next;
  logic [LCNT_W-1:0] l, l_next, nedges, nedges_next, e, e_next;
  logic [VCNT_W-1:0] j, j_next, vcount, vcount_next, pass, pass_next;
  logic [VCNT_W-1:0] i, i_next, len, len_next, kout, kout_next;
  logic [DCNT_W-1:0] k, k_next;
  phase_t phase, phase_next;
  logic changed, changed_next, have_best, have_best_next;
  logic [ADDR_W-1:0] target, target_next, nbr, nbr_next, cand, cand_next;
  logic [COST_W-1:0] cost, cost_next;
  logic [VTX_W-1:0]  a_idx, a_idx_next, hit, hit_next, best, best_next;
  logic [VTX_W-1:0]  cur, cur_next, s_idx, s_idx_next;
  logic [DIST_W-1:0] best_d, best_d_next, cand_d, cand_d_next;

  logic [ADDR_W-1:0] va_q;
  logic [DIST_W-1:0] dist_a_q, dist_b_q;
  logic [PAR_W-1:0]  par_q;
  logic [EDGE_W-1:0] edge_q;
  logic [VTX_W-1:0]  path_q;

  logic [VTX_W-1:0] va_ridx, da_ridx, par_ridx, path_ridx;
  logic [LINK_W-1:0] edge_ridx;
  logic va_we, dist_we, par_we, edge_we, path_we;
  logic [VTX_W-1:0] va_widx, dist_widx, par_widx, path_widx;
  logic [ADDR_W-1:0] va_wdata;
  logic [DIST_W-1:0] dist_wdata;
  logic [PAR_W-1:0]  par_wdata;
  logic [VTX_W-1:0]  edge_f, edge_t;
  logic [COST_W-1:0] edge_c;
  logic [DIST_W:0]   nd;
  logic [VCNT_W-1:0] path_pos;

  assign {edge_f, edge_t, edge_c} = edge_q;
  assign nd = {1'b0, dist_a_q} + (DIST_W + 1)'(edge_c);
  assign path_pos = len - VCNT_W'(1) - kout;
  assign idle = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      reached <= '0;
      vcount <= '0;
    end else begin
      state <= state_next;
      reached <= reached_next;
      vcount <= vcount_next;
    end
  end

  always_ff @(posedge clk) begin
    l <= l_next; nedges <= nedges_next; e <= e_next; j <= j_next;
    pass <= pass_next; i <= i_next; len <= len_next; kout <= kout_next;
    k <= k_next; phase <= phase_next; changed <= changed_next;
    have_best <= have_best_next; target <= target_next; nbr <= nbr_next;
    cand <= cand_next; cost <= cost_next; a_idx <= a_idx_next; hit <= hit_next;
    best <= best_next; cur <= cur_next; s_idx <= s_idx_next;
    best_d <= best_d_next; cand_d <= cand_d_next;
  end

  // vertex, edge and path stores
  always_ff @(posedge clk) begin
    if (va_we) va_mem[va_widx] <= va_wdata;
    if (dist_we) dist_mem[dist_widx] <= dist_wdata;
    if (par_we) par_mem[par_widx] <= par_wdata;
    if (edge_we) edge_mem[nedges[LINK_W-1:0]] <= {a_idx, hit, cost};
    if (path_we) path_mem[path_widx] <= cur;
    va_q     <= va_mem[va_ridx];
    dist_a_q <= dist_mem[da_ridx];
    dist_b_q <= dist_mem[edge_t];
    par_q    <= par_mem[par_ridx];
    edge_q   <= edge_mem[edge_ridx];
    path_q   <= path_mem[path_ridx];
  end

  always_comb begin
    state_next = state; reached_next = reached; vcount_next = vcount;
    l_next = l; nedges_next = nedges; e_next = e; j_next = j;
    pass_next = pass; i_next = i; len_next = len; kout_next = kout;
    k_next = k; phase_next = phase; changed_next = changed;
    have_best_next = have_best; target_next = target; nbr_next = nbr;
    cand_next = cand; cost_next = cost; a_idx_next = a_idx; hit_next = hit;
    best_next = best; cur_next = cur; s_idx_next = s_idx;
    best_d_next = best_d; cand_d_next = cand_d;

    va_ridx = j[VTX_W-1:0]; da_ridx = edge_f; par_ridx = cur;
    path_ridx = path_pos[VTX_W-1:0]; edge_ridx = e[LINK_W-1:0];
    va_we = 1'b0; va_widx = vcount[VTX_W-1:0]; va_wdata = target;
    dist_we = 1'b0; dist_widx = hit; dist_wdata = '0;
    par_we = 1'b0; par_widx = vcount[VTX_W-1:0]; par_wdata = NO_PARENT;
    edge_we = 1'b0; path_we = 1'b0; path_widx = len[VTX_W-1:0];

    req = '0;
    req.link_idx = l[LINK_W-1:0];
    req.dest_idx = k[DEST_W-1:0];
    res = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (tbl.ovf) state_next = ST_OVF_OUT;
          else begin
            vcount_next = '0;
            nedges_next = '0;
            l_next = '0;
            state_next = ST_LINK_RD;
          end
        end
      end
      ST_LINK_RD: begin
        j_next = '0;
        if (l == tbl.link_count) begin
          target_next = source_router;
          phase_next = PH_SOURCE;
          state_next = ST_SRCH_RD;
        end else begin
          req.link_rd = 1'b1;
          state_next = ST_LINK_CHK;
        end
      end
      ST_LINK_CHK: begin
        nbr_next = tbl.neighbor;
        cost_next = tbl.metric;
        target_next = tbl.router;
        phase_next = PH_ROUTER;
        if (tbl.up && tbl.bw >= required_bandwidth) state_next = ST_SRCH_RD;
        else begin
          l_next = l + LCNT_W'(1);
          state_next = ST_LINK_RD;
        end
      end
      // linear lookup of target among the numbered vertices, add when missing
      ST_SRCH_RD: begin
        if (j == vcount) begin
          if (vcount == VCNT_W'(MAX_VERTICES)) begin
            req.set_ovf = 1'b1;
            state_next = ST_OVF_OUT;
          end else begin
            va_we = 1'b1;
            par_we = 1'b1;
            reached_next[vcount[VTX_W-1:0]] = 1'b0;
            hit_next = vcount[VTX_W-1:0];
            vcount_next = vcount + VCNT_W'(1);
            state_next = ST_HIT;
          end
        end else state_next = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (va_q == target) begin
          hit_next = j[VTX_W-1:0];
          state_next = ST_HIT;
        end else begin
          j_next = j + VCNT_W'(1);
          state_next = ST_SRCH_RD;
        end
      end
      ST_HIT: begin
        j_next = '0;
        unique case (phase)
          PH_ROUTER: begin
            a_idx_next = hit;
            target_next = nbr;
            phase_next = PH_NEIGH;
            state_next = ST_SRCH_RD;
          end
          PH_NEIGH: begin
            edge_we = 1'b1;
            nedges_next = nedges + LCNT_W'(1);
            l_next = l + LCNT_W'(1);
            state_next = ST_LINK_RD;
          end
          default: begin
            s_idx_next = hit;
            reached_next[hit] = 1'b1;
            dist_we = 1'b1;
            pass_next = VCNT_W'(1);
            state_next = ST_PASS;
          end
        endcase
      end
      ST_PASS: begin
        e_next = '0;
        changed_next = 1'b0;
        i_next = '0;
        have_best_next = 1'b0;
        if (pass >= vcount) state_next = ST_SEL_RD;
        else state_next = ST_EDGE_RD;
      end
      ST_EDGE_RD: begin
        if (e == nedges) begin
          if (!changed) begin
            pass_next = vcount;
          end else begin
            pass_next = pass + VCNT_W'(1);
          end
          state_next = ST_PASS;
        end else state_next = ST_DIST_RD;
      end
      ST_DIST_RD: state_next = ST_RELAX;
      ST_RELAX: begin
        if (reached[edge_f] && (!reached[edge_t] || nd < {1'b0, dist_b_q})) begin
          dist_we = 1'b1;
          dist_widx = edge_t;
          dist_wdata = nd[DIST_W-1:0];
          par_we = 1'b1;
          par_widx = edge_t;
          par_wdata = PAR_W'(edge_f);
          reached_next[edge_t] = 1'b1;
          changed_next = 1'b1;
        end
        e_next = e + LCNT_W'(1);
        state_next = ST_EDGE_RD;
      end
      ST_SEL_RD: begin
        va_ridx = i[VTX_W-1:0];
        da_ridx = i[VTX_W-1:0];
        len_next = '0;
        cur_next = best;
        if (i == vcount) state_next = have_best ? ST_PATH_WR : ST_NONE_OUT;
        else state_next = ST_SEL_CHK;
      end
      ST_SEL_CHK: begin
        cand_next = va_q;
        cand_d_next = dist_a_q;
        k_next = '0;
        if (reached[i[VTX_W-1:0]] && (!have_best || dist_a_q < best_d)) begin
          state_next = ST_DST_RD;
        end else begin
          i_next = i + VCNT_W'(1);
          state_next = ST_SEL_RD;
        end
      end
      ST_DST_RD: begin
        if (k == tbl.dest_count) begin
          i_next = i + VCNT_W'(1);
          state_next = ST_SEL_RD;
        end else begin
          req.dest_rd = 1'b1;
          state_next = ST_DST_CMP;
        end
      end
      ST_DST_CMP: begin
        if (tbl.dest == cand) begin
          best_next = i[VTX_W-1:0];
          best_d_next = cand_d;
          have_best_next = 1'b1;
          i_next = i + VCNT_W'(1);
          state_next = ST_SEL_RD;
        end else begin
          k_next = k + DCNT_W'(1);
          state_next = ST_DST_RD;
        end
      end
      // walk parents from the chosen destination back to the source
      ST_PATH_WR: begin
        path_we = 1'b1;
        len_next = len + VCNT_W'(1);
        kout_next = '0;
        if (cur == s_idx || len + VCNT_W'(1) >= VCNT_W'(MAX_VERTICES)) begin
          state_next = ST_OUT_RD;
        end else state_next = ST_PATH_PAR;
      end
      ST_PATH_PAR: begin
        if (VCNT_W'(par_q) < vcount) begin
          cur_next = par_q[VTX_W-1:0];
          state_next = ST_PATH_WR;
        end else state_next = ST_OUT_RD;
      end
      ST_OUT_RD: state_next = ST_OUT_VA;
      ST_OUT_VA: begin
        va_ridx = path_q;
        state_next = ST_OUT_PUT;
      end
      ST_OUT_PUT: begin
        // keep the hop address steady while the output stalls
        va_ridx = path_q;
        if (out_free) begin
          res.load = 1'b1;
          res.hop = va_q;
          res.found = 1'b1;
          res.last = (kout == len - VCNT_W'(1));
          if (res.last) state_next = ST_IDLE;
          else begin
            kout_next = kout + VCNT_W'(1);
            state_next = ST_OUT_RD;
          end
        end
      end
      ST_OVF_OUT: begin
        if (out_free) begin
          res.load = 1'b1;
          res.ovf = 1'b1;
          res.last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_NONE_OUT: begin
        if (out_free) begin
          res.load = 1'b1;
          res.last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `CSPU_ASSERT_IMP(a_vcount_bound, clk, rst, 1'b1, vcount <= VCNT_W'(MAX_VERTICES))
  `CSPU_ASSERT_IMP(a_emit_when_free, clk, rst, res.load, out_free)
  `CSPU_ASSERT_IMP(a_relax_in_range, clk, rst, dist_we && state == ST_RELAX, VCNT_W'(edge_t) < vcount)
  `CSPU_ASSERT_NEXT(a_start_leaves_idle, clk, rst, start && state == ST_IDLE, state != ST_IDLE)

endmodule

// File: design/constrained_shortest_path_unit.sv
`timescale 1ns / 1ps
// load, class, destination and clear beats are accepted only while the engine is idle
// compute: a linear address lookup for the router and neighbor of each usable link,
//   edge relaxation passes over all edges (up to vertex count - 1 passes),
//   a selection over reached vertices and destinations, a parent walk, then the path hops
// reset: link, destination and vertex counts and the overflow flag clear, priority_class is 7
module constrained_shortest_path_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // node, neighbor, up, cost, class, bandwidth
  input  logic [2:0]   s_tuser,  // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,  // hop address
  output logic [1:0]   m_tuser,  // bit 1 overflow, bit 0 found
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [39:0]  cfg_data
);
  import cspu_pkg::*;

  logic [31:0] source_router;
  logic [39:0] required_bandwidth;
  logic [2:0]  priority_class;
  load_t       load;
  logic        beat, start, idle, out_free;
  tbl_req_t    req;
  tbl_rsp_t    rsp;
  res_t        res;

  assign cfg_ready = 1'b1;
  assign s_tready  = idle;
  assign beat      = s_tvalid && s_tready;
  assign start     = beat && s_tuser == ACT_COMPUTE;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    load.action   = s_tuser;
    load.node     = s_tdata[31:0];
    load.neighbor = s_tdata[63:32];
    load.up       = s_tdata[64];
    load.cost     = s_tdata[80:65];
    load.cls      = s_tdata[83:81];
    load.bw       = s_tdata[123:84];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_router <= '0;
      required_bandwidth <= '0;
      priority_class <= 3'd7;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SOURCE: source_router <= cfg_data[31:0];
        CFG_BW:     required_bandwidth <= cfg_data;
        CFG_CLASS:  priority_class <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // output register parts result delivery from the engine
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      m_tdata <= res.hop;
      m_tuser <= {res.ovf, res.found};
      m_tlast <= res.last;
    end
  end

  cspu_tables u_tables (
    .clk        (clk),
    .rst        (rst),
    .load_valid (beat),
    .load       (load),
    .pclass     (priority_class),
    .req        (req),
    .rsp        (rsp)
  );

  cspu_solver u_solver (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .source_router      (source_router),
    .required_bandwidth (required_bandwidth),
    .out_free           (out_free),
    .tbl                (rsp),
    .req                (req),
    .res                (res),
    .idle               (idle)
  );

endmodule
